[sv/strmax_pkg.sv]
// ---------------------------------------------------------------------------
// strmax_pkg
// Shared constants, types and helpers for the sparse table range maximum block.
// ---------------------------------------------------------------------------
package strmax_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int VALUE_BITS   = 32;

  localparam int OP_W     = 2;
  localparam int QIDX_W   = 10;
  localparam int STATUS_W = 2;
  localparam int QK_W     = 4;

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int POS_W  = $clog2(MAX_ELEMENTS);
  localparam int K_W    = $clog2(LEVELS + 1);
  localparam int DEPTH  = LEVELS * MAX_ELEMENTS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_BAD,
    RES_FULL,
    RES_MAX
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_APP_WR0,
    S_APP_RD,
    S_APP_WR,
    S_Q_RD1,
    S_Q_RD2,
    S_Q_MAX,
    S_FIN
  } state_t;

  typedef struct packed {
    logic      load_item;
    logic      clear_count;
    logic      wr_level0;
    logic      rd_append;
    logic      wr_append;
    logic      latch_query;
    logic      rd_left;
    logic      rd_right;
    logic      set_pend;
    res_kind_t pend_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            full;
    logic            bad_range;
    logic            more_levels;
    logic            out_free;
  } stat_t;

  function automatic val_t smax(val_t a, val_t b);
    return (a >= b) ? a : b;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(logic [K_W-1:0] level,
                                                 logic [POS_W-1:0] pos);
    return ADDR_W'(32'(level) * 32'(MAX_ELEMENTS) + 32'(pos));
  endfunction

  function automatic logic [QK_W-1:0] floor_log2(logic [QIDX_W:0] x);
    logic [QK_W-1:0] k;
    k = '0;
    for (int i = 0; i <= QIDX_W; i++) begin
      if (x[i]) k = QK_W'(i);
    end
    return k;
  endfunction

endpackage

[sv/strmax_ram.sv]
// ---------------------------------------------------------------------------
// strmax_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module strmax_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

[sv/strmax_ctrl.sv]
// ---------------------------------------------------------------------------
// strmax_ctrl
// Sequencer: decodes each item and steps the datapath through table fill
// or query reads, then hands the result to the output register.
// ---------------------------------------------------------------------------
module strmax_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  strmax_pkg::stat_t  stat,
  output strmax_pkg::cmd_t   cmd
);

  strmax_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= strmax_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != strmax_pkg::S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.pend_kind = strmax_pkg::RES_OK;
    case (state)
      strmax_pkg::S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = strmax_pkg::S_DECODE;
        end
      end
      strmax_pkg::S_DECODE: begin
        case (stat.opcode)
          strmax_pkg::OP_APPEND: begin
            if (stat.full) begin
              cmd.set_pend  = 1'b1;
              cmd.pend_kind = strmax_pkg::RES_FULL;
              state_next    = strmax_pkg::S_FIN;
            end else begin
              state_next = strmax_pkg::S_APP_WR0;
            end
          end
          strmax_pkg::OP_QUERY: begin
            if (stat.bad_range) begin
              cmd.set_pend  = 1'b1;
              cmd.pend_kind = strmax_pkg::RES_BAD;
              state_next    = strmax_pkg::S_FIN;
            end else begin
              cmd.latch_query = 1'b1;
              state_next      = strmax_pkg::S_Q_RD1;
            end
          end
          strmax_pkg::OP_CLEAR: begin
            cmd.clear_count = 1'b1;
            cmd.set_pend    = 1'b1;
            state_next      = strmax_pkg::S_FIN;
          end
          default: begin
            cmd.set_pend = 1'b1;
            state_next   = strmax_pkg::S_FIN;
          end
        endcase
      end
      strmax_pkg::S_APP_WR0: begin
        cmd.wr_level0 = 1'b1;
        state_next    = strmax_pkg::S_APP_RD;
      end
      strmax_pkg::S_APP_RD: begin
        if (stat.more_levels) begin
          cmd.rd_append = 1'b1;
          state_next    = strmax_pkg::S_APP_WR;
        end else begin
          cmd.set_pend = 1'b1;
          state_next   = strmax_pkg::S_FIN;
        end
      end
      strmax_pkg::S_APP_WR: begin
        cmd.wr_append = 1'b1;
        state_next    = strmax_pkg::S_APP_RD;
      end
      strmax_pkg::S_Q_RD1: begin
        cmd.rd_left = 1'b1;
        state_next  = strmax_pkg::S_Q_RD2;
      end
      strmax_pkg::S_Q_RD2: begin
        cmd.rd_right = 1'b1;
        state_next   = strmax_pkg::S_Q_MAX;
      end
      strmax_pkg::S_Q_MAX: begin
        cmd.set_pend  = 1'b1;
        cmd.pend_kind = strmax_pkg::RES_MAX;
        state_next    = strmax_pkg::S_FIN;
      end
      strmax_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = strmax_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = strmax_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[sv/strmax_dp.sv]
// ---------------------------------------------------------------------------
// strmax_dp
// Datapath: item registers, element count, level walk, running window max,
// table addressing and the output register.
// ---------------------------------------------------------------------------
module strmax_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  strmax_pkg::cmd_t                    cmd,
  output strmax_pkg::stat_t                   stat,
  input  logic [strmax_pkg::OP_W-1:0]         opcode,
  input  strmax_pkg::val_t                    value,
  input  logic [strmax_pkg::QIDX_W-1:0]       query_left,
  input  logic [strmax_pkg::QIDX_W-1:0]       query_right,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [strmax_pkg::STATUS_W-1:0]     status,
  output strmax_pkg::val_t                    max_value,
  output logic                                ram_wr_en,
  output logic [strmax_pkg::ADDR_W-1:0]       ram_wr_addr,
  output strmax_pkg::val_t                    ram_wr_data,
  output logic                                ram_rd_en,
  output logic [strmax_pkg::ADDR_W-1:0]       ram_rd_addr,
  input  strmax_pkg::val_t                    ram_rd_data
);

  logic [strmax_pkg::OP_W-1:0]     op_r;
  strmax_pkg::val_t                val_r;
  logic [strmax_pkg::QIDX_W-1:0]   left_r;
  logic [strmax_pkg::QIDX_W-1:0]   right_r;
  logic [strmax_pkg::CNT_W-1:0]    count;
  logic [strmax_pkg::POS_W-1:0]    pos;
  logic [strmax_pkg::K_W-1:0]      lvl;
  strmax_pkg::val_t                carry;
  logic [strmax_pkg::K_W-1:0]      q_lvl;
  logic [strmax_pkg::POS_W-1:0]    q_s2;
  strmax_pkg::val_t                first_max;
  logic [strmax_pkg::STATUS_W-1:0] pend_status;
  strmax_pkg::val_t                pend_value;

  logic [strmax_pkg::QIDX_W:0]     qlen;
  logic [strmax_pkg::QK_W-1:0]     qk;
  logic [strmax_pkg::POS_W-1:0]    app_start;
  logic [strmax_pkg::POS_W-1:0]    q_s2_calc;
  strmax_pkg::val_t                new_max;

  assign qlen      = {1'b0, right_r} - {1'b0, left_r} + (strmax_pkg::QIDX_W + 1)'(1);
  assign qk        = strmax_pkg::floor_log2(qlen);
  assign app_start = strmax_pkg::POS_W'(32'(pos) + 32'd1 - (32'd1 << lvl));
  assign q_s2_calc = strmax_pkg::POS_W'(32'(right_r) + 32'd1 - (32'd1 << qk));
  assign new_max   = strmax_pkg::smax(ram_rd_data, carry);

  assign stat.opcode      = op_r;
  assign stat.full        = (32'(count) >= strmax_pkg::MAX_ELEMENTS);
  assign stat.bad_range   = (left_r > right_r) || (32'(right_r) >= 32'(count)) ||
                            (32'(qk) >= strmax_pkg::LEVELS);
  assign stat.more_levels = (32'(lvl) < strmax_pkg::LEVELS) &&
                            ((32'd1 << lvl) <= (32'(pos) + 32'd1));
  assign stat.out_free    = !result_valid || !result_stall;

  always_comb begin
    ram_wr_en   = cmd.wr_level0 || cmd.wr_append;
    ram_wr_addr = strmax_pkg::mem_addr(lvl, app_start);
    ram_wr_data = new_max;
    if (cmd.wr_level0) begin
      ram_wr_addr = strmax_pkg::mem_addr('0, pos);
      ram_wr_data = val_r;
    end
  end

  always_comb begin
    ram_rd_en   = cmd.rd_append || cmd.rd_left || cmd.rd_right;
    ram_rd_addr = strmax_pkg::mem_addr(lvl - strmax_pkg::K_W'(1), app_start);
    if (cmd.rd_left) begin
      ram_rd_addr = strmax_pkg::mem_addr(q_lvl, strmax_pkg::POS_W'(left_r));
    end else if (cmd.rd_right) begin
      ram_rd_addr = strmax_pkg::mem_addr(q_lvl, q_s2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.wr_level0) begin
        count <= count + strmax_pkg::CNT_W'(1);
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r    <= opcode;
      val_r   <= value;
      left_r  <= query_left;
      right_r <= query_right;
      pos     <= strmax_pkg::POS_W'(count);
    end
    if (cmd.wr_level0) begin
      lvl   <= strmax_pkg::K_W'(1);
      carry <= val_r;
    end else if (cmd.wr_append) begin
      lvl   <= lvl + strmax_pkg::K_W'(1);
      carry <= new_max;
    end
    if (cmd.latch_query) begin
      q_lvl <= strmax_pkg::K_W'(qk);
      q_s2  <= q_s2_calc;
    end
    if (cmd.rd_right) first_max <= ram_rd_data;
    if (cmd.set_pend) begin
      case (cmd.pend_kind)
        strmax_pkg::RES_BAD: begin
          pend_status <= strmax_pkg::STAT_BAD_RANGE;
          pend_value  <= '0;
        end
        strmax_pkg::RES_FULL: begin
          pend_status <= strmax_pkg::STAT_FULL;
          pend_value  <= '0;
        end
        strmax_pkg::RES_MAX: begin
          pend_status <= strmax_pkg::STAT_OK;
          pend_value  <= strmax_pkg::smax(first_max, ram_rd_data);
        end
        default: begin
          pend_status <= strmax_pkg::STAT_OK;
          pend_value  <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      status    <= pend_status;
      max_value <= pend_value;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= strmax_pkg::MAX_ELEMENTS)
    else $error("element count above capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && result_stall))
    else $error("pending result overwritten");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_append |-> (32'(lvl) < strmax_pkg::LEVELS))
    else $error("table write beyond top level");

  a_read_then_write: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_append |=> cmd.wr_append)
    else $error("window read not followed by its write");

endmodule

[sv/sparse_table_range_max.sv]
// Clear, unused opcode, full and bad range go straight to the result; a query reads two
// table words; an append writes level 0 and then fills levels 1 up to LEVELS-1.
// Each filled level costs a table read then a write on the single table RAM port pair.
// One item at a time; the next beat is taken the cycle after its result is registered.
// Synchronous active-high reset empties the array; table contents stay undefined.
// ---------------------------------------------------------------------------
// sparse_table_range_max
// Range maximum over appended signed values, kept as a sparse table of
// power-of-two window maxima in one RAM.
// ---------------------------------------------------------------------------
module sparse_table_range_max (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [strmax_pkg::OP_W-1:0]     opcode,
  input  strmax_pkg::val_t                value,
  input  logic [strmax_pkg::QIDX_W-1:0]   query_left,
  input  logic [strmax_pkg::QIDX_W-1:0]   query_right,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [strmax_pkg::STATUS_W-1:0] status,
  output strmax_pkg::val_t                max_value
);

  strmax_pkg::cmd_t                cmd;
  strmax_pkg::stat_t               stat;
  logic                            ram_wr_en;
  logic [strmax_pkg::ADDR_W-1:0]   ram_wr_addr;
  strmax_pkg::val_t                ram_wr_data;
  logic                            ram_rd_en;
  logic [strmax_pkg::ADDR_W-1:0]   ram_rd_addr;
  strmax_pkg::val_t                ram_rd_data;

  strmax_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  strmax_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .value        (value),
    .query_left   (query_left),
    .query_right  (query_right),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .max_value    (max_value),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  strmax_ram #(
    .WIDTH (strmax_pkg::VALUE_BITS),
    .DEPTH (strmax_pkg::DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
